/* sv/analog_key_rapid_trigger_scanner_top_defines.svh */
// Assertion macros used by the checker of this block.
`ifndef ANALOG_KEY_RAPID_TRIGGER_SCANNER_TOP_DEFINES_SVH
`define ANALOG_KEY_RAPID_TRIGGER_SCANNER_TOP_DEFINES_SVH

// Implication checked in the next cycle, ignored while reset is held.
`define AKRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, ignored while reset is held.
`define AKRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, also across reset.
`define AKRT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/akrt_pkg.sv */
package akrt_pkg;

    localparam int SLOTS          = 4;
    localparam int KEY_COUNT_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SPEED_SCALE    = 1000;
    localparam int SPEED_BITS     = 16;
    localparam int POS_REG_BITS   = 48;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CODE_BITS      = 8;

    localparam logic [CODE_BITS-1:0] ESC_CODE = 8'h29;
    localparam logic [CODE_BITS-1:0] NO_CODE  = 8'h00;

    localparam logic [CODE_BITS-1:0] KEY_CODES [SLOTS] = '{8'h07, 8'h09, 8'h0D, 8'h0E};

    typedef enum logic [1:0] {
        PH_RELEASED  = 2'd0,
        PH_PRESSING  = 2'd1,
        PH_PRESSED   = 2'd2,
        PH_RELEASING = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POS_THR   = 3'd0,
        CFG_TRIG      = 3'd1,
        CFG_REL       = 3'd2,
        CFG_QUICK     = 3'd3,
        CFG_REPORT_EN = 3'd4
    } t_cfg_idx;

endpackage

/* sv/akrt_key.sv */
module akrt_key
    import akrt_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_pos_thr,
    input  logic [SPEED_BITS-1:0]  i_trig_speed,
    input  logic [SPEED_BITS-1:0]  i_rel_speed,
    input  logic                   i_quick,
    input  logic [CODE_BITS-1:0]   i_key_code,
    output t_phase                 o_phase,
    output logic [CODE_BITS-1:0]   o_code
);

    // The difference spans SAMPLE_BITS+1 signed bits; times 1000 adds ten more.
    localparam int SPW = SAMPLE_BITS + 11;

    t_phase                  r_phase;
    logic [SAMPLE_BITS-1:0]  r_prev;
    logic [CODE_BITS-1:0]    r_held;

    t_phase                  n_phase;
    logic [CODE_BITS-1:0]    n_held;

    logic signed [SAMPLE_BITS:0] w_diff;
    logic signed [SPW-1:0]       w_diff_ext;
    logic signed [SPW-1:0]       w_speed;
    logic signed [SPW-1:0]       w_trig;
    logic signed [SPW-1:0]       w_rel;
    logic                        w_at_pos;

    assign w_diff     = signed'({1'b0, i_sample}) - signed'({1'b0, r_prev});
    assign w_diff_ext = SPW'(w_diff);
    assign w_speed    = w_diff_ext * SPW'(SPEED_SCALE);
    assign w_trig     = SPW'(signed'(i_trig_speed));
    assign w_rel      = SPW'(signed'(i_rel_speed));
    assign w_at_pos   = (i_sample >= i_pos_thr);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_RELEASED: begin
                priority if (w_at_pos)         n_phase = PH_PRESSED;
                else if (w_speed >= w_trig)    n_phase = PH_PRESSING;
                else                           n_phase = r_phase;
            end
            PH_PRESSING: begin
                priority if (w_at_pos)         n_phase = PH_PRESSED;
                else if (w_speed < w_trig)     n_phase = PH_RELEASED;
                else if (w_speed < w_rel)      n_phase = PH_RELEASING;
                else                           n_phase = r_phase;
            end
            PH_PRESSED: begin
                priority if (!w_at_pos)        n_phase = PH_RELEASED;
                else if (w_speed < w_rel)      n_phase = PH_RELEASING;
                else                           n_phase = r_phase;
            end
            PH_RELEASING: begin
                priority if (!w_at_pos)        n_phase = PH_RELEASED;
                else if (w_speed > w_rel)      n_phase = PH_PRESSED;
                else if (w_speed >= w_trig)    n_phase = PH_PRESSING;
                else                           n_phase = r_phase;
            end
            default: n_phase = r_phase;
        endcase
    end

    // In normal mode the slot only changes on a full press or a full release.
    always_comb begin
        n_held = r_held;
        if (i_quick) begin
            n_held = (n_phase == PH_PRESSING || n_phase == PH_PRESSED) ? i_key_code : NO_CODE;
        end else if (n_phase == PH_PRESSED) begin
            n_held = i_key_code;
        end else if (n_phase == PH_RELEASED) begin
            n_held = NO_CODE;
        end
    end

    assign o_phase = n_phase;
    assign o_code  = n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
            r_prev  <= '0;
            r_held  <= NO_CODE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_prev  <= i_sample;
            r_held  <= n_held;
        end
    end

endmodule

/* sv/analog_key_rapid_trigger_scanner_top.sv */
// Rapid-trigger scanner for up to four analog keys and an escape button. Each
// accepted scan word carries one position sample per key; every key steps its
// released / pressing / pressed / releasing machine from the sample, a speed of
// (sample - previous sample) * 1000 and its configured thresholds, and one report
// word comes out per scan. The per-key logic sits between the input port and a
// single result register, so a scan is accepted every cycle and its report is
// valid on the next cycle; the result register is the only stage, and input
// ready drops only while a report waits on a stalled output. Configuration
// writes take effect at the clock edge and should be made while no scan is
// in flight. Keys at or beyond KEY_COUNT report code 0 and phase 0.
module analog_key_rapid_trigger_scanner_top
    import akrt_pkg::*;
#(
    parameter int KEY_COUNT   = KEY_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,

    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [SAMPLE_BITS-1:0]   i_sample_one,
    input  logic [SAMPLE_BITS-1:0]   i_sample_two,
    input  logic [SAMPLE_BITS-1:0]   i_sample_three,
    input  logic [SAMPLE_BITS-1:0]   i_sample_four,
    input  logic                     i_escape_pressed,

    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_send_report,
    output logic [CODE_BITS-1:0]     o_code_one,
    output logic [CODE_BITS-1:0]     o_code_two,
    output logic [CODE_BITS-1:0]     o_code_three,
    output logic [CODE_BITS-1:0]     o_code_four,
    output logic [CODE_BITS-1:0]     o_escape_code,
    output logic [1:0]               o_phase_one,
    output logic [1:0]               o_phase_two,
    output logic [1:0]               o_phase_three,
    output logic [1:0]               o_phase_four
);

    localparam int ACTIVE = (KEY_COUNT < SLOTS) ? KEY_COUNT : SLOTS;
    localparam int POS_EXT_BITS = (SAMPLE_BITS * SLOTS > POS_REG_BITS) ?
                                  SAMPLE_BITS * SLOTS : POS_REG_BITS;

    logic [POS_REG_BITS-1:0]        r_pos_thr;
    logic [CFG_DATA_BITS-1:0]       r_trig;
    logic [CFG_DATA_BITS-1:0]       r_rel;
    logic                           r_quick;
    logic                           r_report_en;

    logic                           r_out_valid;
    logic                           r_send;
    logic [CODE_BITS-1:0]           r_esc;
    logic [CODE_BITS-1:0]           r_code  [SLOTS];
    t_phase                         r_phase [SLOTS];

    logic                           w_accept;
    logic [POS_EXT_BITS-1:0]        w_pos_ext;
    logic [SAMPLE_BITS-1:0]         w_sample [SLOTS];
    logic [CODE_BITS-1:0]           n_code   [SLOTS];
    t_phase                         n_phase  [SLOTS];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pos_ext  = POS_EXT_BITS'(r_pos_thr);

    assign w_sample[0] = i_sample_one;
    assign w_sample[1] = i_sample_two;
    assign w_sample[2] = i_sample_three;
    assign w_sample[3] = i_sample_four;

    for (genvar k = 0; k < SLOTS; k++) begin : g_slot
        if (k < ACTIVE) begin : g_key
            akrt_key #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_key (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_step       (w_accept),
                .i_sample     (w_sample[k]),
                .i_pos_thr    (w_pos_ext[SAMPLE_BITS*k +: SAMPLE_BITS]),
                .i_trig_speed (r_trig[SPEED_BITS*k +: SPEED_BITS]),
                .i_rel_speed  (r_rel[SPEED_BITS*k +: SPEED_BITS]),
                .i_quick      (r_quick),
                .i_key_code   (KEY_CODES[k]),
                .o_phase      (n_phase[k]),
                .o_code       (n_code[k])
            );
        end else begin : g_idle
            assign n_phase[k] = PH_RELEASED;
            assign n_code[k]  = NO_CODE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_thr   <= '0;
            r_trig      <= '0;
            r_rel       <= '0;
            r_quick     <= 1'b0;
            r_report_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POS_THR:   r_pos_thr   <= i_cfg_data[POS_REG_BITS-1:0];
                CFG_TRIG:      r_trig      <= i_cfg_data;
                CFG_REL:       r_rel       <= i_cfg_data;
                CFG_QUICK:     r_quick     <= i_cfg_data[0];
                CFG_REPORT_EN: r_report_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_send  <= r_report_en;
            r_esc   <= i_escape_pressed ? ESC_CODE : NO_CODE;
            r_code  <= n_code;
            r_phase <= n_phase;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_send_report = r_send;
    assign o_escape_code = r_esc;
    assign o_code_one    = r_code[0];
    assign o_code_two    = r_code[1];
    assign o_code_three  = r_code[2];
    assign o_code_four   = r_code[3];
    assign o_phase_one   = r_phase[0];
    assign o_phase_two   = r_phase[1];
    assign o_phase_three = r_phase[2];
    assign o_phase_four  = r_phase[3];

endmodule

/* sv/akrt_checker.sv */
`include "analog_key_rapid_trigger_scanner_top_defines.svh"

module akrt_checker
    import akrt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 i_escape_pressed,
    input logic [CODE_BITS-1:0] o_escape_code,
    input logic [CODE_BITS-1:0] o_code_one,
    input logic [1:0]           o_phase_one
);

    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Released key one never holds a code, in either report mode.
    `AKRT_ASSERT_NOW(a_released_no_code, i_clk, i_rst_n, o_out_valid && o_phase_one == PH_RELEASED, o_code_one == NO_CODE, "released key one reports a code")

    `AKRT_ASSERT_NEXT(a_escape_code, i_clk, i_rst_n, w_in_acc && i_escape_pressed, o_out_valid && o_escape_code == ESC_CODE, "escape slot missing after escape scan")

    `AKRT_ASSERT_NEXT(a_drain, i_clk, i_rst_n, w_out_acc && !w_in_acc, !o_out_valid, "report repeated after it was taken")

    `AKRT_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "report valid right after reset")

endmodule

bind analog_key_rapid_trigger_scanner_top akrt_checker u_akrt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .i_escape_pressed (i_escape_pressed),
    .o_escape_code    (o_escape_code),
    .o_code_one       (o_code_one),
    .o_phase_one      (o_phase_one)
);
